[src/mcc_pkg.sv]
// Shared types and constants of the minimum coin change block.
package mcc_pkg;

  localparam int unsigned MaxAmountDefault = 1023;

  localparam int unsigned AmountW = 10;
  localparam int unsigned CoinW   = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned CfgIdxW = 2;

  // Table marker for an amount that no coin combination reaches.
  localparam logic [CountW-1:0] NoWay = {CountW{1'b1}};

  localparam logic [CoinW-1:0] CoinAReset = CoinW'(1);
  localparam logic [CoinW-1:0] CoinBReset = CoinW'(3);
  localparam logic [CoinW-1:0] CoinCReset = CoinW'(5);

  localparam logic [CfgIdxW-1:0] CfgCoinA = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCoinB = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCoinC = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_RUN  = 5'b00100,
    S_LAST = 5'b01000,
    S_DONE = 5'b10000
  } mcc_state_e;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } mcc_phase_e;

  typedef struct packed {
    logic              fits;
    logic [CountW-1:0] cand;
  } mcc_relax_t;

endpackage

[src/mcc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/mcc_relax_unit.sv]
// Shared unit: forms the table address for one coin and folds one read entry into the best count.
module mcc_relax_unit import mcc_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic [AW-1:0]     amount_i,
  input  logic [CoinW-1:0]  coin_i,
  input  logic [CountW-1:0] best_i,
  input  logic [CountW-1:0] prev_i,
  input  logic              chk_i,
  output logic [AW-1:0]     addr_o,
  output mcc_relax_t        res_o
);

  localparam int unsigned CalcW = ((AW > CoinW) ? AW : CoinW) + 1;

  logic [CalcW-1:0]  diff;
  logic [CountW-1:0] prev_inc;

  assign diff     = CalcW'(amount_i) - CalcW'(coin_i);
  assign addr_o   = diff[AW-1:0];
  assign prev_inc = prev_i + CountW'(1);

  // A coin fits when it is nonzero and the difference does not borrow.
  assign res_o.fits = (coin_i != '0) && !diff[CalcW-1];
  assign res_o.cand = (chk_i && (prev_i != NoWay) && (prev_inc < best_i)) ? prev_inc : best_i;

endmodule

[src/min_coin_change_dp.sv]
// Top level of the minimum coin change block: sequencer, coin registers and result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   input   | in        | in_valid_i / in_stall_o | target_amount_i
//   result  | out       | out_valid_o / out_stall_i | min_coins_o, unreachable_o
//   config  | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// A target T in 1..MAX_AMOUNT is worked through the table entries 1..T before the result register;
// each table entry needs three reads of the single table read port, one per coin.
// A zero or over-range target skips the table walk and goes straight to the result.
// Reset clears the sequencer and the result valid flag and sets the coins to 1, 3 and 5.
// The table needs no clearing: every entry is written before it is read.
// A stalled result is held while the next item is already accepted and worked on.
module min_coin_change_dp import mcc_pkg::*; #(
  parameter int unsigned MAX_AMOUNT = MaxAmountDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [AmountW-1:0] target_amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CoinW-1:0]   min_coins_o,
  output logic               unreachable_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoinW-1:0]   cfg_data_i
);

  localparam int unsigned Depth = MAX_AMOUNT + 1;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  mcc_state_e state_q, state_d;
  mcc_phase_e phase_q, phase_d;
  logic [AW-1:0]     i_q, i_d;
  logic [AW-1:0]     tgt_q, tgt_d;
  logic [CountW-1:0] best_q, best_d;
  logic              arr_q, arr_d;
  logic              chk_q, chk_d;
  logic              byp_q;
  logic [CountW-1:0] byp_data_q;
  logic [CoinW-1:0]  res_cnt_q, res_cnt_d;
  logic              res_unr_q, res_unr_d;
  logic              out_valid_q;
  logic [CoinW-1:0]  min_coins_q;
  logic              unreachable_q;
  logic [CoinW-1:0]  coin_a_q, coin_b_q, coin_c_q;

  logic [CoinW-1:0]  coin_sel;
  logic [AW-1:0]     rd_addr;
  logic [CountW-1:0] ram_rdata;
  logic [CountW-1:0] prev;
  logic              ram_we;
  logic [AW-1:0]     wr_addr;
  logic [CountW-1:0] wr_data;
  logic              in_acc;
  logic              out_free;
  logic              over_range;
  mcc_relax_t        relax;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign over_range = (32'(target_amount_i) > 32'(MAX_AMOUNT));
  assign prev       = byp_q ? byp_data_q : ram_rdata;

  always_comb begin
    unique case (phase_q)
      PH_A:    coin_sel = coin_a_q;
      PH_B:    coin_sel = coin_b_q;
      PH_C:    coin_sel = coin_c_q;
      default: coin_sel = coin_a_q;
    endcase
  end

  mcc_relax_unit #(
    .AW(AW)
  ) u_relax (
    .amount_i(i_q),
    .coin_i  (coin_sel),
    .best_i  (best_q),
    .prev_i  (prev),
    .chk_i   (chk_q && arr_q),
    .addr_o  (rd_addr),
    .res_o   (relax)
  );

  mcc_ram #(
    .Width(CountW),
    .Depth(Depth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Read data arrives in the cycle after the read; the check flag travels with it.
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    i_d       = i_q;
    tgt_d     = tgt_q;
    best_d    = best_q;
    arr_d     = 1'b0;
    chk_d     = relax.fits;
    res_cnt_d = res_cnt_q;
    res_unr_d = res_unr_q;
    ram_we    = 1'b0;
    wr_addr   = i_q - AW'(1);
    wr_data   = relax.cand;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (over_range) begin
            res_cnt_d = '0;
            res_unr_d = 1'b1;
            state_d   = S_DONE;
          end else if (target_amount_i == '0) begin
            res_cnt_d = '0;
            res_unr_d = 1'b0;
            state_d   = S_DONE;
          end else begin
            tgt_d   = AW'(target_amount_i);
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        ram_we  = 1'b1;
        wr_addr = '0;
        wr_data = '0;
        i_d     = AW'(1);
        phase_d = PH_A;
        best_d  = NoWay;
        state_d = S_RUN;
      end
      S_RUN: begin
        arr_d = 1'b1;
        unique case (phase_q)
          PH_A: begin
            // The third coin of the previous entry lands now; store that entry.
            ram_we  = arr_q;
            best_d  = NoWay;
            phase_d = PH_B;
          end
          PH_B: begin
            best_d  = relax.cand;
            phase_d = PH_C;
          end
          PH_C: begin
            best_d  = relax.cand;
            phase_d = PH_A;
            if (i_q == tgt_q) begin
              state_d = S_LAST;
            end else begin
              i_d = i_q + AW'(1);
            end
          end
          default: phase_d = PH_A;
        endcase
      end
      S_LAST: begin
        if (relax.cand == NoWay) begin
          res_cnt_d = '0;
          res_unr_d = 1'b1;
        end else begin
          res_cnt_d = relax.cand[CoinW-1:0];
          res_unr_d = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_A;
      arr_q       <= 1'b0;
      out_valid_q <= 1'b0;
      coin_a_q    <= CoinAReset;
      coin_b_q    <= CoinBReset;
      coin_c_q    <= CoinCReset;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      arr_q   <= arr_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgCoinA: coin_a_q <= cfg_data_i;
          CfgCoinB: coin_b_q <= cfg_data_i;
          CfgCoinC: coin_c_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    tgt_q      <= tgt_d;
    best_q     <= best_d;
    chk_q      <= chk_d;
    res_cnt_q  <= res_cnt_d;
    res_unr_q  <= res_unr_d;
    byp_q      <= ram_we && (wr_addr == rd_addr);
    byp_data_q <= wr_data;
    if (state_q == S_DONE && out_free) begin
      min_coins_q   <= res_cnt_q;
      unreachable_q <= res_unr_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_coins_o   = min_coins_q;
  assign unreachable_o = unreachable_q;

  a_write_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INIT || state_q == S_RUN))
    else $error("table written outside a table walk");

  a_index_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> (i_q != '0 && i_q <= tgt_q))
    else $error("walk index outside 1..target");

  a_last_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LAST |-> ($past(state_q) == S_RUN && $past(phase_q) == PH_C))
    else $error("final fold not preceded by the third coin read");

  a_unreachable_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unreachable_o) |-> (min_coins_o == '0))
    else $error("unreachable result carries a nonzero count");

  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free) |=> state_q == S_DONE)
    else $error("pending result dropped while output is stalled");

endmodule

[dv/tb_min_coin_change_dp.sv]
// Self-checking testbench for the minimum coin change block: directed vectors, then random traffic.
`timescale 1ns / 1ps

module tb_min_coin_change_dp;
  import mcc_pkg::*;

  localparam int unsigned NumDirected = 23;
  localparam int unsigned NumPhases = 5;
  localparam int unsigned ItemsPerPhase = 34;
  localparam int unsigned LongHold = 400;
  // The register index past the three coins; a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [CoinW-1:0] coins;
    logic             unreach;
  } change_t;

  typedef struct packed {
    logic [CoinW-1:0]   den_a;
    logic [CoinW-1:0]   den_b;
    logic [CoinW-1:0]   den_c;
    logic [AmountW-1:0] amt;
    logic               known;
    change_t            answer;
  } vector_t;

  // Rows with known set carry an answer read straight off the coin values.
  localparam vector_t DirVec [NumDirected] = '{
    '{10'd1, 10'd3, 10'd5, 10'd0, 1'b1, '{10'd0, 1'b0}},
    '{10'd1, 10'd3, 10'd5, 10'd1, 1'b1, '{10'd1, 1'b0}},
    '{10'd1, 10'd3, 10'd5, 10'd5, 1'b1, '{10'd1, 1'b0}},
    '{10'd1, 10'd3, 10'd5, 10'd7, 1'b0, '{10'd0, 1'b0}},
    '{10'd1, 10'd3, 10'd5, 10'd1023, 1'b1, '{10'd205, 1'b0}},
    '{10'd1, 10'd3, 10'd5, 10'd1022, 1'b0, '{10'd0, 1'b0}},
    '{10'd2, 10'd4, 10'd6, 10'd7, 1'b1, '{10'd0, 1'b1}},
    '{10'd2, 10'd4, 10'd6, 10'd1023, 1'b1, '{10'd0, 1'b1}},
    '{10'd2, 10'd4, 10'd6, 10'd0, 1'b1, '{10'd0, 1'b0}},
    '{10'd2, 10'd4, 10'd6, 10'd1022, 1'b0, '{10'd0, 1'b0}},
    '{10'd0, 10'd0, 10'd0, 10'd5, 1'b1, '{10'd0, 1'b1}},
    '{10'd0, 10'd0, 10'd0, 10'd0, 1'b1, '{10'd0, 1'b0}},
    '{10'd0, 10'd7, 10'd0, 10'd14, 1'b1, '{10'd2, 1'b0}},
    '{10'd0, 10'd7, 10'd0, 10'd13, 1'b1, '{10'd0, 1'b1}},
    '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{10'd1, 1'b0}},
    '{10'd1023, 10'd1023, 10'd1023, 10'd1022, 1'b1, '{10'd0, 1'b1}},
    '{10'd1, 10'd1, 10'd1, 10'd1023, 1'b1, '{10'd1023, 1'b0}},
    '{10'd1, 10'd1, 10'd1, 10'd512, 1'b0, '{10'd0, 1'b0}},
    '{10'd1023, 10'd1, 10'd512, 10'd1023, 1'b1, '{10'd1, 1'b0}},
    '{10'd512, 10'd511, 10'd1, 10'd1023, 1'b1, '{10'd2, 1'b0}},
    '{10'd3, 10'd5, 10'd1023, 10'd1, 1'b1, '{10'd0, 1'b1}},
    '{10'd3, 10'd5, 10'd1023, 10'd7, 1'b1, '{10'd0, 1'b1}},
    '{10'd682, 10'd341, 10'd1, 10'd1023, 1'b1, '{10'd2, 1'b0}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [AmountW-1:0] target_amount_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CoinW-1:0]   min_coins_o;
  logic               unreachable_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoinW-1:0]   cfg_data_i = '0;

  // Our copy of the coin registers and the count table.
  logic [CoinW-1:0]  denom_a = CoinAReset;
  logic [CoinW-1:0]  denom_b = CoinBReset;
  logic [CoinW-1:0]  denom_c = CoinCReset;
  logic [CountW-1:0] coins_for_amt [0:MaxAmountDefault];

  change_t pending_change [$];
  int      err_cnt = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      coin_sets = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  bit      hold_req = 1'b0;
  bit      hold_ack = 1'b0;
  int      hold_left = 0;

  min_coin_change_dp dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .target_amount_i(target_amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .min_coins_o    (min_coins_o),
    .unreachable_o  (unreachable_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("tb_min_coin_change_dp: FAIL");
    $finish;
  end

  // Fewest coins for an amount under the current denominations, built bottom-up.
  function automatic change_t fewest_coins(input logic [AmountW-1:0] amt);
    logic [CountW-1:0] best;
    logic [CoinW-1:0]  denom [3];
    change_t           res;
    denom = '{denom_a, denom_b, denom_c};
    coins_for_amt[0] = '0;
    for (int i = 1; i <= int'(amt); i++) begin
      best = NoWay;
      for (int k = 0; k < 3; k++) begin
        if (denom[k] != '0 && int'(denom[k]) <= i) begin
          if (coins_for_amt[i - int'(denom[k])] != NoWay &&
              coins_for_amt[i - int'(denom[k])] + 1 < best) begin
            best = coins_for_amt[i - int'(denom[k])] + 1'b1;
          end
        end
      end
      coins_for_amt[i] = best;
    end
    if (coins_for_amt[amt] == NoWay) begin
      res = '{coins: '0, unreach: 1'b1};
    end else begin
      res = '{coins: coins_for_amt[amt][CoinW-1:0], unreach: 1'b0};
    end
    return res;
  endfunction

  function automatic logic [CoinW-1:0] rand_coin();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick <= 6) return CoinW'($urandom_range(1, 12));
    return CoinW'($urandom_range(1, 1023));
  endfunction

  // Mostly short tables so the run stays fast; now and then the full range.
  function automatic logic [AmountW-1:0] rand_amount();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return AmountW'($urandom_range(0, 40));
    if (pick < 94) return AmountW'($urandom_range(0, 1023));
    return AmountW'(1023 - $urandom_range(0, 1));
  endfunction

  // Offers one item, waits for its acceptance and records what must come back.
  task automatic send_target(input logic [AmountW-1:0] amt, input change_t answer);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_amount_i <= amt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_change.push_back(answer);
    items_sent++;
  endtask

  // Lowers valid at the current edge and waits until every result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_change.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoinW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_coins(input logic [CoinW-1:0] a, input logic [CoinW-1:0] b,
                           input logic [CoinW-1:0] c);
    drain();
    write_reg(CfgCoinA, a);
    write_reg(CfgCoinB, b);
    write_reg(CfgCoinC, c);
    write_reg(CfgUnused, CoinW'($urandom_range(0, 1023)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    denom_a = a;
    denom_b = b;
    denom_c = c;
    coin_sets++;
  endtask

  // Result side: random stall, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = LongHold;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    if (hold_left != 0) hold_left = hold_left - 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_change.size() == 0) begin
        $display("%0t: unexpected result: min_coins %0d unreachable %0b",
                 $time, min_coins_o, unreachable_o);
        err_cnt++;
      end else begin
        if (min_coins_o !== pending_change[0].coins) begin
          $display("%0t: min_coins expected %0d actual %0d",
                   $time, pending_change[0].coins, min_coins_o);
          err_cnt++;
        end
        if (unreachable_o !== pending_change[0].unreach) begin
          $display("%0t: unreachable expected %0b actual %0b",
                   $time, pending_change[0].unreach, unreachable_o);
          err_cnt++;
        end
        void'(pending_change.pop_front());
      end
    end
  end

  initial begin
    logic [AmountW-1:0] amt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed vectors, starting from the reset coins 1, 3 and 5.
    for (int r = 0; r < int'(NumDirected); r++) begin
      if (DirVec[r].den_a != denom_a || DirVec[r].den_b != denom_b ||
          DirVec[r].den_c != denom_c) begin
        set_coins(DirVec[r].den_a, DirVec[r].den_b, DirVec[r].den_c);
      end
      send_target(DirVec[r].amt,
                  DirVec[r].known ? DirVec[r].answer : fewest_coins(DirVec[r].amt));
    end

    // Random phases: no idling, sender idle, receiver stalling, both, then both under a long result hold-off.
    for (int ph = 0; ph < int'(NumPhases); ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      set_coins(rand_coin(), rand_coin(), rand_coin());
      if (ph == int'(NumPhases) - 1) hold_req = !hold_req;
      for (int n = 0; n < int'(ItemsPerPhase); n++) begin
        // The sender pauses here until the block has handed back everything.
        if (n == int'(ItemsPerPhase) / 2) set_coins(rand_coin(), rand_coin(), rand_coin());
        if (ph == int'(NumPhases) - 1 && n < 10) amt = AmountW'($urandom_range(0, 10));
        else amt = rand_amount();
        send_target(amt, fewest_coins(amt));
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d items and checked %0d results over %0d coin settings,",
             items_sent, results_seen, coin_sets);
    $display("with zero coins, unreachable targets and a long result hold-off.");
    if (err_cnt == 0) begin
      $display("tb_min_coin_change_dp: PASS");
    end else begin
      $display("tb_min_coin_change_dp: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/mcc_pkg.sv
src/mcc_ram.sv
src/mcc_relax_unit.sv
src/min_coin_change_dp.sv
dv/tb_min_coin_change_dp.sv
